// ===== hdl/fdr_pkg.sv =====
// Shared constants and types of the Fresnel dielectric reflectance core.
`timescale 1ns / 1ps
`default_nettype none
package fdr_pkg;

	// Fixed-point constants
	localparam int CosW     = 16;
	localparam int IndexW   = 16;
	localparam int AbsW     = 15;                  // |cos| in Q14, up to 16384
	localparam logic signed [CosW-1:0] CosOne    = 16'sd16384;
	localparam logic signed [CosW-1:0] CosNegOne = -16'sd16384;
	localparam logic [15:0] OneQ15 = 16'd32768;

	// Pipelined divider geometry
	localparam int DivQw = 29;                     // quotient bits, one per stage
	localparam int DivNw = 61;                     // dividend bits
	localparam int DivDw = 32;                     // divisor bits

	// Square root geometry
	localparam int SqrtSteps = 15;
	localparam int RadW      = 29;

	// Total pipeline depth, input register to output register
	localparam int PipeDepth = 3 + DivQw + SqrtSteps + 2 + DivQw + 2;

	// Register map
	localparam int AddrW = 3;
	localparam logic RegIncident    = 1'b0;
	localparam logic RegTransmitted = 1'b1;
	localparam logic [IndexW-1:0] IncidentReset    = 16'd4096;
	localparam logic [IndexW-1:0] TransmittedReset = 16'd6144;

	// Side data that rides along the first divider and the square root
	typedef struct packed {
		logic              leaving;
		logic              tir;
		logic [AbsW-1:0]   a;
		logic [IndexW-1:0] ni;
		logic [IndexW-1:0] nt;
	} side_t;

	// Flags that ride along the ratio dividers
	typedef struct packed {
		logic leaving;
		logic tir;
		logic dz;
	} flag_t;

endpackage
`default_nettype wire

// ===== hdl/fdr_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module fdr_divider (
	input  wire logic                        clk,
	input  wire logic                        en,
	input  wire logic [fdr_pkg::DivNw-1:0]   num,
	input  wire logic [fdr_pkg::DivDw-1:0]   den,
	output logic      [fdr_pkg::DivQw-1:0]   quo
);

	logic [fdr_pkg::DivNw-1:0] rem_s [fdr_pkg::DivQw];
	logic [fdr_pkg::DivDw-1:0] den_s [fdr_pkg::DivQw];
	logic [fdr_pkg::DivQw-1:0] quo_s [fdr_pkg::DivQw];

	genvar i;
	generate
		for (i = 0; i < fdr_pkg::DivQw; i++) begin : g_step
			localparam int Bit = fdr_pkg::DivQw - 1 - i;
			logic [fdr_pkg::DivNw-1:0] rem_in;
			logic [fdr_pkg::DivDw-1:0] den_in;
			logic [fdr_pkg::DivQw-1:0] quo_in;
			logic [fdr_pkg::DivNw-1:0] trial;
			logic                      ge;

			if (i == 0) begin : g_first
				assign rem_in = num;
				assign den_in = den;
				assign quo_in = '0;
			end else begin : g_next
				assign rem_in = rem_s[i-1];
				assign den_in = den_s[i-1];
				assign quo_in = quo_s[i-1];
			end

			// Trial subtract of the shifted divisor
			assign trial = fdr_pkg::DivNw'(den_in) << Bit;
			assign ge    = rem_in >= trial;

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[i] <= ge ? rem_in - trial : rem_in;
					den_s[i] <= den_in;
					quo_s[i] <= quo_in | (fdr_pkg::DivQw'(ge) << Bit);
				end
			end
		end
	endgenerate

	assign quo = quo_s[fdr_pkg::DivQw-1];

endmodule
`default_nettype wire

// ===== hdl/fresnel_dielectric_reflectance_core.sv =====
// Top level of the Fresnel dielectric reflectance core.
//
// Usage: cosine samples (signed Q2.14) arrive as beats on the s_ channel, one
// per cycle at most. Each produces one beat on the m_ channel carrying the
// unpolarized reflectance (unsigned Q1.15) in m_tdata and the total internal
// reflection and leaving flags in m_tuser. The two refractive indices are
// set over the APB port at addresses 0 and 4; the user must set them only
// while the core is idle, as the core itself does not enforce this.
// Pipeline: 3 setup stages, a 29-stage divider for the transmitted sine,
// a 15-stage square root, 2 product stages, two 29-stage ratio dividers in
// parallel, a squaring stage and the output register.
// Throughput is one beat per cycle. When the receiver stalls with a result
// waiting, the whole pipeline holds and s_tready drops; nothing is lost or
// repeated. Reset clears all valid bits and loads the indices with 1.0 and
// 1.5.
`timescale 1ns / 1ps
`default_nettype none
module fresnel_dielectric_reflectance_core (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// input beats
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	input  wire logic [15:0]                s_tdata,  // [15:0] cos_incident
	// output beats
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic [15:0]                     m_tdata,  // [15:0] reflectance
	output logic [1:0]                      m_tuser,  // [0] total_internal, [1] leaving
	// configuration
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [fdr_pkg::AddrW-1:0]  paddr,
	input  wire logic [31:0]                pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);

	localparam int IW = fdr_pkg::IndexW;
	localparam int AW = fdr_pkg::AbsW;

	// Configuration registers
	logic [IW-1:0] ni_cfg_q, nt_cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ni_cfg_q <= fdr_pkg::IncidentReset;
			nt_cfg_q <= fdr_pkg::TransmittedReset;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				fdr_pkg::RegIncident:    ni_cfg_q <= pwdata[IW-1:0];
				fdr_pkg::RegTransmitted: nt_cfg_q <= pwdata[IW-1:0];
				default: ;
			endcase
		end
	end

	assign pready = 1'b1;
	always_comb begin
		unique case (paddr[2])
			fdr_pkg::RegIncident:    prdata = {16'd0, ni_cfg_q};
			fdr_pkg::RegTransmitted: prdata = {16'd0, nt_cfg_q};
			default:                 prdata = '0;
		endcase
	end

	// Global advance: the pipeline moves unless a result is stuck at the end
	logic                        en;
	logic [fdr_pkg::PipeDepth-1:0] valid_q;

	assign en       = !valid_q[fdr_pkg::PipeDepth-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = valid_q[fdr_pkg::PipeDepth-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (en) begin
			valid_q <= {valid_q[fdr_pkg::PipeDepth-2:0], s_tvalid};
		end
	end

	// Stage 1: clamp, direction, index swap
	logic signed [15:0] cos_in, cos_cl;
	logic               lv_in;
	logic [AW-1:0]      a_s1;
	logic               lv_s1;
	logic [IW-1:0]      ni_s1, nt_s1;

	always_comb begin
		cos_in = signed'(s_tdata);
		if (cos_in > fdr_pkg::CosOne)
			cos_cl = fdr_pkg::CosOne;
		else if (cos_in < fdr_pkg::CosNegOne)
			cos_cl = fdr_pkg::CosNegOne;
		else
			cos_cl = cos_in;
		lv_in = cos_cl <= 16'sd0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lv_s1 <= lv_in;
			a_s1  <= lv_in ? AW'(-cos_cl) : AW'(cos_cl);
			ni_s1 <= lv_in ? nt_cfg_q : ni_cfg_q;
			nt_s1 <= lv_in ? ni_cfg_q : nt_cfg_q;
		end
	end

	// Stage 2: squares
	logic [28:0]   aa_s2;
	logic [31:0]   ni2_s2, nt2_s2;
	fdr_pkg::side_t sd_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			aa_s2  <= 29'(a_s1 * a_s1);
			ni2_s2 <= 32'(ni_s1 * ni_s1);
			nt2_s2 <= 32'(nt_s1 * nt_s1);
			sd_s2  <= '{leaving: lv_s1, tir: 1'b0, a: a_s1, ni: ni_s1, nt: nt_s1};
		end
	end

	// Stage 3: ni^2 * sin^2 of the incidence angle
	logic [fdr_pkg::DivNw-1:0] num_s3;
	logic [31:0]               nt2_s3;
	fdr_pkg::side_t            sd_s3;
	logic [28:0]               s2i;

	assign s2i = 29'd268435456 - aa_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			num_s3 <= fdr_pkg::DivNw'(ni2_s2 * s2i);
			nt2_s3 <= nt2_s2;
			sd_s3  <= sd_s2;
		end
	end

	// Total internal reflection test, exact
	logic tir3;
	assign tir3 = (sd_s3.nt == '0) || (num_s3 > {1'b0, nt2_s3, 28'd0});

	// Transmitted sine squared
	logic [fdr_pkg::DivQw-1:0] s2t;
	fdr_divider u_div_sine (
		.clk (clk),
		.en  (en),
		.num (num_s3),
		.den (nt2_s3),
		.quo (s2t)
	);

	fdr_pkg::side_t sd_dv_s [fdr_pkg::DivQw];
	always_ff @(posedge clk) begin
		if (en) begin
			sd_dv_s[0] <= '{leaving: sd_s3.leaving, tir: tir3, a: sd_s3.a,
				ni: sd_s3.ni, nt: sd_s3.nt};
			for (int k = 1; k < fdr_pkg::DivQw; k++)
				sd_dv_s[k] <= sd_dv_s[k-1];
		end
	end

	// Radicand 1 - sin^2, with the sine squared clamped to one
	logic [fdr_pkg::RadW-1:0] rad;
	assign rad = (s2t > 29'd268435456) ? '0 : 29'd268435456 - s2t;

	// Square root, one root bit per stage
	logic [fdr_pkg::RadW-1:0] sq_rem_s  [fdr_pkg::SqrtSteps];
	logic [AW-1:0]            sq_root_s [fdr_pkg::SqrtSteps];
	fdr_pkg::side_t           sd_sq_s   [fdr_pkg::SqrtSteps];

	genvar j;
	generate
		for (j = 0; j < fdr_pkg::SqrtSteps; j++) begin : g_sqrt
			localparam int Bit = fdr_pkg::SqrtSteps - 1 - j;
			logic [fdr_pkg::RadW-1:0] rem_in;
			logic [AW-1:0]            root_in;
			fdr_pkg::side_t           sd_in;
			logic [30:0]              trial;
			logic                     ge;

			if (j == 0) begin : g_first
				assign rem_in  = rad;
				assign root_in = '0;
				assign sd_in   = sd_dv_s[fdr_pkg::DivQw-1];
			end else begin : g_next
				assign rem_in  = sq_rem_s[j-1];
				assign root_in = sq_root_s[j-1];
				assign sd_in   = sd_sq_s[j-1];
			end

			// (r + 2^k)^2 - r^2 = 2r*2^k + 4^k
			assign trial = ((31'(root_in) << 1) << Bit) + (31'd1 << (2 * Bit));
			assign ge    = 31'(rem_in) >= trial;

			always_ff @(posedge clk) begin
				if (en) begin
					sq_rem_s[j]  <= ge ? fdr_pkg::RadW'(31'(rem_in) - trial) : rem_in;
					sq_root_s[j] <= root_in | (AW'(ge) << Bit);
					sd_sq_s[j]   <= sd_in;
				end
			end
		end
	endgenerate

	// Product stage
	logic [30:0]    p1_s, p2_s, p3_s, p4_s;
	fdr_pkg::flag_t fl_p_s;
	fdr_pkg::side_t sd_last;
	logic [AW-1:0]  b_last;

	assign sd_last = sd_sq_s[fdr_pkg::SqrtSteps-1];
	assign b_last  = sq_root_s[fdr_pkg::SqrtSteps-1];

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s   <= 31'(sd_last.nt * sd_last.a);
			p2_s   <= 31'(sd_last.ni * b_last);
			p3_s   <= 31'(sd_last.ni * sd_last.a);
			p4_s   <= 31'(sd_last.nt * b_last);
			fl_p_s <= '{leaving: sd_last.leaving, tir: sd_last.tir, dz: 1'b0};
		end
	end

	// Sum and difference stage
	logic [31:0]    d1_s, d2_s;
	logic [30:0]    n1_s, n2_s;
	fdr_pkg::flag_t fl_d_s;
	logic [31:0]    d1c, d2c;

	assign d1c = 32'(p1_s) + 32'(p2_s);
	assign d2c = 32'(p3_s) + 32'(p4_s);

	always_ff @(posedge clk) begin
		if (en) begin
			d1_s   <= d1c;
			d2_s   <= d2c;
			n1_s   <= (p1_s >= p2_s) ? p1_s - p2_s : p2_s - p1_s;
			n2_s   <= (p3_s >= p4_s) ? p3_s - p4_s : p4_s - p3_s;
			fl_d_s <= '{leaving: fl_p_s.leaving, tir: fl_p_s.tir,
				dz: (d1c == '0) || (d2c == '0)};
		end
	end

	// Fresnel ratios in Q24
	logic [fdr_pkg::DivQw-1:0] q1, q2;
	fdr_divider u_div_par (
		.clk (clk),
		.en  (en),
		.num ({6'd0, n1_s, 24'd0}),
		.den (d1_s),
		.quo (q1)
	);
	fdr_divider u_div_perp (
		.clk (clk),
		.en  (en),
		.num ({6'd0, n2_s, 24'd0}),
		.den (d2_s),
		.quo (q2)
	);

	fdr_pkg::flag_t fl_dv_s [fdr_pkg::DivQw];
	always_ff @(posedge clk) begin
		if (en) begin
			fl_dv_s[0] <= fl_d_s;
			for (int k = 1; k < fdr_pkg::DivQw; k++)
				fl_dv_s[k] <= fl_dv_s[k-1];
		end
	end

	// Squaring stage
	logic [49:0]    sq1_s, sq2_s;
	fdr_pkg::flag_t fl_sq_s;

	always_ff @(posedge clk) begin
		if (en) begin
			sq1_s   <= 50'(q1[24:0] * q1[24:0]);
			sq2_s   <= 50'(q2[24:0] * q2[24:0]);
			fl_sq_s <= fl_dv_s[fdr_pkg::DivQw-1];
		end
	end

	// Output register: mean, round half up, saturate
	logic [50:0] sum;
	logic [16:0] rnd;
	logic [15:0] refl_q;
	logic [1:0]  user_q;

	assign sum = 51'(sq1_s) + 51'(sq2_s) + (51'd1 << 33);
	assign rnd = sum[50:34];

	always_ff @(posedge clk) begin
		if (en) begin
			if (fl_sq_s.tir || fl_sq_s.dz)
				refl_q <= fdr_pkg::OneQ15;
			else if (rnd > 17'(fdr_pkg::OneQ15))
				refl_q <= fdr_pkg::OneQ15;
			else
				refl_q <= rnd[15:0];
			user_q <= {fl_sq_s.leaving, fl_sq_s.tir};
		end
	end

	assign m_tdata = refl_q;
	assign m_tuser = user_q;

endmodule
`default_nettype wire
